// ===== rtl/phlm_pkg.sv =====
package phlm_pkg;

	localparam int NUM_BANDS_DEF = 16;

	localparam int LEVEL_W  = 10;
	localparam int HOLD_W   = 8;
	localparam int BAND_W   = 4;
	localparam int SAMPLE_W = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;

	localparam logic [LEVEL_W-1:0] RST_MAX_LEVEL   = 10'd100;
	localparam logic [HOLD_W-1:0]  RST_HOLD_TICKS  = 8'd10;
	localparam logic [LEVEL_W-1:0] RST_LEVEL_DECAY = 10'd10;
	localparam logic [LEVEL_W-1:0] RST_PEAK_DECAY  = 10'd5;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_DECAY = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PEAK_DECAY  = 3'd3;

	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_TICK   = 1'b1;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic [LEVEL_W-1:0] peak;
		logic [HOLD_W-1:0]  hold;
	} band_entry_t;

	localparam int ENTRY_W = $bits(band_entry_t);

	localparam band_entry_t ENTRY_RST = '{
		level: RST_MAX_LEVEL,
		peak:  RST_MAX_LEVEL,
		hold:  RST_HOLD_TICKS
	};

endpackage

// ===== rtl/phlm_ram.sv =====
module phlm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/peak_hold_level_meter_unit.sv =====
// sample: accepted in idle, then read, update and output (done); a band out of range goes straight to done
// tick: walks all bands in turn through one ram read/update loop, then registers
//   the result from the done state
// one item at a time: no new request is taken until the last has left done, which waits while a result waits
// reset: asynchronous, clears control, loads register defaults and clears the
//   per-band valid bits so every band reads as its reset level, peak and hold
module peak_hold_level_meter_unit #(
	parameter int NUM_BANDS = phlm_pkg::NUM_BANDS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                cfg_we,
	input  logic [phlm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [phlm_pkg::CFG_DATA_W-1:0]     cfg_wdata,

	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                req_type,
	input  logic [phlm_pkg::BAND_W-1:0]         band_index,
	input  logic signed [phlm_pkg::SAMPLE_W-1:0] sample_value,

	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [phlm_pkg::LEVEL_W-1:0]        band_level,
	output logic [phlm_pkg::LEVEL_W-1:0]        peak_level,
	output logic [phlm_pkg::HOLD_W-1:0]         hold_left,
	output logic                                activity
);

	localparam int IDX_W = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BANDS - 1);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_READ   = 4'b0010,
		S_UPDATE = 4'b0100,
		S_DONE   = 4'b1000
	} state_t;

	state_t state_q;

	logic [phlm_pkg::LEVEL_W-1:0] max_level_q;
	logic [phlm_pkg::HOLD_W-1:0]  hold_ticks_q;
	logic [phlm_pkg::LEVEL_W-1:0] level_decay_q;
	logic [phlm_pkg::LEVEL_W-1:0] peak_decay_q;

	logic                           req_q;
	logic [phlm_pkg::BAND_W-1:0]    band_q;
	logic [phlm_pkg::SAMPLE_W-1:0]  sample_q;
	logic [IDX_W-1:0]               cnt_q;
	logic                           act_q;
	logic [NUM_BANDS-1:0]           valid_q;
	phlm_pkg::band_entry_t          rep_q;

	logic                           out_valid_q;
	phlm_pkg::band_entry_t          out_q;
	logic                           out_act_q;

	logic                           accept;
	logic                           in_range;
	logic [phlm_pkg::ENTRY_W-1:0]   ram_rdata;
	phlm_pkg::band_entry_t          ent_cur;
	phlm_pkg::band_entry_t          ent_new;
	logic                           ent_act;
	logic [phlm_pkg::LEVEL_W-1:0]   smp_lvl;
	logic [phlm_pkg::HOLD_W-1:0]    hold_dec;
	logic                           ram_we;
	logic                           is_rep;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign in_range = ({5'b0, band_index} < 9'(NUM_BANDS));

	assign out_valid  = out_valid_q;
	assign band_level = out_q.level;
	assign peak_level = out_q.peak;
	assign hold_left  = out_q.hold;
	assign activity   = out_act_q;

	phlm_ram #(
		.WIDTH(phlm_pkg::ENTRY_W),
		.DEPTH(NUM_BANDS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q),
		.wdata (ent_new),
		.raddr (cnt_q),
		.rdata (ram_rdata)
	);

	// the shared update unit
	always_comb begin
		ent_cur = valid_q[cnt_q] ? phlm_pkg::band_entry_t'(ram_rdata) : phlm_pkg::ENTRY_RST;
		ent_new = ent_cur;
		ent_act = 1'b0;
		hold_dec = '0;
		if (sample_q[phlm_pkg::SAMPLE_W-1]) begin
			smp_lvl = '0;
		end else if (sample_q[phlm_pkg::SAMPLE_W-2:0] > {5'b0, max_level_q}) begin
			smp_lvl = max_level_q;
		end else begin
			smp_lvl = sample_q[phlm_pkg::LEVEL_W-1:0];
		end
		if (req_q == phlm_pkg::REQ_TICK) begin
			ent_new.level = (ent_cur.level > level_decay_q) ?
				(ent_cur.level - level_decay_q) : '0;
			hold_dec = (ent_cur.hold != '0) ? (ent_cur.hold - 8'd1) : '0;
			ent_new.hold = hold_dec;
			if (hold_dec == '0 && ent_cur.peak != '0) begin
				ent_new.peak = (ent_cur.peak > peak_decay_q) ?
					(ent_cur.peak - peak_decay_q) : '0;
			end
			ent_act = (ent_cur.level != '0) || (ent_cur.hold != '0) ||
				(hold_dec == '0 && ent_cur.peak != '0);
		end else begin
			ent_new.level = smp_lvl;
			if (ent_cur.peak < smp_lvl) begin
				ent_new.peak = smp_lvl;
				ent_new.hold = hold_ticks_q;
			end
		end
	end

	assign ram_we = (state_q == S_UPDATE);
	assign is_rep = (cnt_q == IDX_W'(band_q)) && ({5'b0, band_q} < 9'(NUM_BANDS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_level_q   <= phlm_pkg::RST_MAX_LEVEL;
			hold_ticks_q  <= phlm_pkg::RST_HOLD_TICKS;
			level_decay_q <= phlm_pkg::RST_LEVEL_DECAY;
			peak_decay_q  <= phlm_pkg::RST_PEAK_DECAY;
		end else if (cfg_we) begin
			case (cfg_index)
				phlm_pkg::REG_MAX_LEVEL: begin
					max_level_q <= cfg_wdata;
				end
				phlm_pkg::REG_HOLD_TICKS: begin
					hold_ticks_q <= cfg_wdata[phlm_pkg::HOLD_W-1:0];
				end
				phlm_pkg::REG_LEVEL_DECAY: begin
					level_decay_q <= cfg_wdata;
				end
				phlm_pkg::REG_PEAK_DECAY: begin
					peak_decay_q <= cfg_wdata;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req_type == phlm_pkg::REQ_TICK) begin
							cnt_q   <= '0;
							state_q <= S_READ;
						end else if (in_range) begin
							cnt_q   <= IDX_W'(band_index);
							state_q <= S_READ;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_READ: begin
					state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					valid_q[cnt_q] <= 1'b1;
					if (req_q == phlm_pkg::REQ_TICK && cnt_q != LAST_IDX) begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_READ;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item payload, report capture and output data
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q    <= req_type;
			band_q   <= band_index;
			sample_q <= sample_value;
			act_q    <= 1'b0;
			rep_q    <= '0;
		end
		if (state_q == S_UPDATE) begin
			if (ent_act) begin
				act_q <= 1'b1;
			end
			if (is_rep) begin
				rep_q <= ent_new;
			end
		end
		if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
			out_q     <= rep_q;
			out_act_q <= act_q;
		end
	end

endmodule
